// ===== sv/fth_pkg.sv =====
// shared types and constants for the frame tagged history buffer
package fth_pkg;

   localparam int FRAME_BITS           = 31;
   localparam int CMD_BITS             = 2;
   localparam int STATUS_BITS          = 2;
   localparam int DEFAULT_DEPTH        = 512;
   localparam int DEFAULT_PAYLOAD_BITS = 64;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SAVE  = 2'd0,
      CMD_GET   = 2'd1,
      CMD_TRIM  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_TRIM_STOP = 2'd2;

   // strobes from the sequencer to the entry store
   typedef struct packed {
      logic rd_en;
      logic wr_frame;
      logic wr_payload;
   } mem_ctl_type;

endpackage

// ===== sv/fth_if.sv =====
// valid/ready channel interfaces for commands and results
interface fth_req_if #(
   parameter int PW = fth_pkg::DEFAULT_PAYLOAD_BITS
);
   import fth_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   cmd;
   logic [FRAME_BITS-1:0] frame_tag;
   logic [PW-1:0]         payload_in;

   modport source (output valid, cmd, frame_tag, payload_in, input ready);
   modport sink   (input valid, cmd, frame_tag, payload_in, output ready);
endinterface

interface fth_rsp_if #(
   parameter int PW = fth_pkg::DEFAULT_PAYLOAD_BITS
);
   import fth_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [FRAME_BITS-1:0]  frame_out;
   logic [PW-1:0]          payload_out;

   modport source (output valid, status, frame_out, payload_out, input ready);
   modport sink   (input valid, status, frame_out, payload_out, output ready);
endinterface

// ===== sv/frame_tagged_history_buffer.sv =====
// top level of the frame tagged history buffer
// save/get/trim: walk the stored entries newest first, each with a read strobe (S_ISSUE)
//   and an evaluation (S_EVAL) on the registered read data; S_RESP then registers the result
// clear: one entry written per cycle in S_CLEAR, then S_RESP registers the result
// throughput: one item in flight; the next item is taken once the result is registered
// reset: synchronous; starts a clearing pass over every entry, req ready stays low meanwhile
module frame_tagged_history_buffer #(
   parameter int HISTORY_DEPTH = fth_pkg::DEFAULT_DEPTH,
   parameter int PAYLOAD_BITS  = fth_pkg::DEFAULT_PAYLOAD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   fth_req_if.sink    req_chan,
   fth_rsp_if.source  rsp_chan
);
   import fth_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   // strobes and addresses between the sequencer and the entry store
   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [FRAME_BITS-1:0] wr_frame;
   logic [PAYLOAD_BITS-1:0] wr_payload;
   logic [FRAME_BITS-1:0] rd_frame;
   logic [PAYLOAD_BITS-1:0] rd_payload;

   // sequencer: holds the ring pointers, walks entries newest first,
   // runs the clearing sweep and owns the result register
   fth_ctrl #(
      .DEPTH (HISTORY_DEPTH),
      .PW    (PAYLOAD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_frame   (wr_frame),
      .wr_payload (wr_payload),
      .rd_frame   (rd_frame),
      .rd_payload (rd_payload)
   );

   // entry store, read data is registered and lands in the cycle after the read strobe
   fth_mem #(
      .DEPTH (HISTORY_DEPTH),
      .PW    (PAYLOAD_BITS)
   ) u_mem (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_frame   (wr_frame),
      .wr_payload (wr_payload),
      .rd_frame   (rd_frame),
      .rd_payload (rd_payload)
   );

   // the walk never reads and writes the store in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> !(mem_ctl.wr_frame || mem_ctl.wr_payload))
      else $error("memory read and write in one cycle");

   // a frame is only written together with its payload
   a_frame_with_payload: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_frame |-> mem_ctl.wr_payload)
      else $error("frame written without payload");

   // one item at a time: after an accept the input side closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item accepted while another is in flight");

   // no store access while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !mem_ctl.rd_en && !mem_ctl.wr_frame)
      else $error("store accessed while idle");

endmodule

// ===== sv/fth_mem.sv =====
// entry store: frame and payload memories with one registered read port
module fth_mem #(
   parameter int  DEPTH = fth_pkg::DEFAULT_DEPTH,
   parameter int  PW    = fth_pkg::DEFAULT_PAYLOAD_BITS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  fth_pkg::mem_ctl_type            mem_ctl,
   input  logic [AW-1:0]                   rd_addr,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [fth_pkg::FRAME_BITS-1:0]  wr_frame,
   input  logic [PW-1:0]                   wr_payload,
   output logic [fth_pkg::FRAME_BITS-1:0]  rd_frame,
   output logic [PW-1:0]                   rd_payload
);
   import fth_pkg::*;

   logic [FRAME_BITS-1:0] frame_mem [DEPTH];
   logic [PW-1:0]         pay_mem   [DEPTH];
   logic [FRAME_BITS-1:0] rd_frame_ff;
   logic [PW-1:0]         rd_payload_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_frame) begin
         frame_mem[wr_addr] <= wr_frame;
      end
      if (mem_ctl.rd_en) begin
         rd_frame_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_payload) begin
         pay_mem[wr_addr] <= wr_payload;
      end
      if (mem_ctl.rd_en) begin
         rd_payload_ff <= pay_mem[rd_addr];
      end
   end

   assign rd_frame   = rd_frame_ff;
   assign rd_payload = rd_payload_ff;

endmodule

// ===== sv/fth_ctrl.sv =====
// command sequencer: ring pointers, entry walk, clearing sweep, result register
module fth_ctrl #(
   parameter int  DEPTH = fth_pkg::DEFAULT_DEPTH,
   parameter int  PW    = fth_pkg::DEFAULT_PAYLOAD_BITS,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   fth_req_if.sink                         req_chan,
   fth_rsp_if.source                       rsp_chan,
   output fth_pkg::mem_ctl_type            mem_ctl,
   output logic [AW-1:0]                   rd_addr,
   output logic [AW-1:0]                   wr_addr,
   output logic [fth_pkg::FRAME_BITS-1:0]  wr_frame,
   output logic [PW-1:0]                   wr_payload,
   input  logic [fth_pkg::FRAME_BITS-1:0]  rd_frame,
   input  logic [PW-1:0]                   rd_payload
);
   import fth_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_ISSUE = 5'b00100,
      S_EVAL  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [FRAME_BITS-1:0]  tag_ff, tag_in;
   logic [PW-1:0]          pay_ff, pay_in;
   logic [AW-1:0]          k_ff, k_in;
   logic                   first_ff, first_in;
   logic [AW-1:0]          oldest_ff, oldest_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          sweep_ff, sweep_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [FRAME_BITS-1:0]  res_frame_ff, res_frame_in;
   logic [PW-1:0]          res_pay_ff, res_pay_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [PW-1:0]          rsp_pay_ff, rsp_pay_in;

   logic [AW:0]            slot_sum;
   logic [AW-1:0]          cur_slot;
   logic [AW-1:0]          next_slot;
   logic [AW-1:0]          oldest_next;
   logic                   frame_lt;
   logic                   frame_eq;

   // ring slot of entry k counted from the oldest
   always_comb begin
      slot_sum = {1'b0, oldest_ff} + {1'b0, k_ff};
      if (slot_sum >= (AW+1)'(DEPTH)) begin
         cur_slot = AW'(slot_sum - (AW+1)'(DEPTH));
      end else begin
         cur_slot = slot_sum[AW-1:0];
      end
      next_slot   = (cur_slot == AW'(DEPTH - 1)) ? '0 : cur_slot + 1'b1;
      oldest_next = (oldest_ff == AW'(DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   end

   assign frame_lt = rd_frame < tag_ff;
   assign frame_eq = rd_frame == tag_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tag_in        = tag_ff;
      pay_in        = pay_ff;
      k_in          = k_ff;
      first_in      = first_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_pay_in    = rsp_pay_ff;
      mem_ctl       = '0;
      rd_addr       = cur_slot;
      wr_addr       = cur_slot;
      wr_frame      = tag_ff;
      wr_payload    = pay_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in        = cmd_type'(req_chan.cmd);
               tag_in        = req_chan.frame_tag;
               pay_in        = req_chan.payload_in;
               k_in          = AW'(count_ff - 1'b1);
               first_in      = 1'b1;
               res_status_in = ST_OK;
               res_frame_in  = '0;
               res_pay_in    = '0;
               if (cmd_type'(req_chan.cmd) == CMD_CLEAR) begin
                  sweep_in   = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_CLEAR: begin
            mem_ctl.wr_frame   = 1'b1;
            mem_ctl.wr_payload = 1'b1;
            wr_addr            = sweep_ff;
            wr_frame           = FRAME_BITS'(sweep_ff);
            wr_payload         = '0;
            sweep_in           = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               oldest_in = '0;
               count_in  = CW'(DEPTH);
               state_in  = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_ISSUE: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_EVAL;
         end
         S_EVAL: begin
            first_in = 1'b0;
            case (cmd_ff)
               CMD_SAVE: begin
                  if (first_ff && frame_lt) begin
                     // newer than the newest entry: append, dropping the oldest when full
                     mem_ctl.wr_frame   = 1'b1;
                     mem_ctl.wr_payload = 1'b1;
                     wr_addr            = next_slot;
                     if (count_ff == CW'(DEPTH)) begin
                        oldest_in = oldest_next;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_RESP;
                  end else if (frame_eq) begin
                     mem_ctl.wr_payload = 1'b1;
                     state_in           = S_RESP;
                  end else if (frame_lt || k_ff == '0) begin
                     res_status_in = ST_MISS;
                     state_in      = S_RESP;
                  end else begin
                     k_in     = k_ff - 1'b1;
                     state_in = S_ISSUE;
                  end
               end
               CMD_GET: begin
                  if (frame_eq) begin
                     res_frame_in = rd_frame;
                     res_pay_in   = rd_payload;
                     state_in     = S_RESP;
                  end else if (frame_lt || k_ff == '0) begin
                     res_status_in = ST_MISS;
                     state_in      = S_RESP;
                  end else begin
                     k_in     = k_ff - 1'b1;
                     state_in = S_ISSUE;
                  end
               end
               CMD_TRIM: begin
                  if (!frame_lt && !frame_eq) begin
                     if (k_ff == '0) begin
                        res_status_in = ST_TRIM_STOP;
                        state_in      = S_RESP;
                     end else begin
                        count_in = CW'(k_ff);
                        k_in     = k_ff - 1'b1;
                        state_in = S_ISSUE;
                     end
                  end else begin
                     state_in = S_RESP;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               rsp_pay_in    = res_pay_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.frame_out   = rsp_frame_ff;
   assign rsp_chan.payload_out = rsp_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         oldest_ff    <= '0;
         count_ff     <= CW'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      tag_ff        <= tag_in;
      pay_ff        <= pay_in;
      k_ff          <= k_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

endmodule
